// ----- src/biquad_iir_with_saturation_unit_defines.svh -----
// Assertion macros for the biquad IIR unit.
// No dependencies; included by the top level.
`ifndef BIQUAD_IIR_WITH_SATURATION_UNIT_DEFINES_SVH
`define BIQUAD_IIR_WITH_SATURATION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BQ_ASSERT_IMPLY(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BQ_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error(msg);

`endif

// ----- src/biquad_pkg.sv -----
// Shared types and constants for the biquad IIR unit.
// No dependencies.
package biquad_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int COEF_WIDTH_DEF = 32;
    localparam int SAMPLE_W       = 32;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_IDX_W      = 3;
    localparam int LIMIT_W        = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0      = 3'd0,
        REG_B1      = 3'd1,
        REG_B2      = 3'd2,
        REG_A1      = 3'd3,
        REG_A2      = 3'd4,
        REG_SAT     = 3'd5,
        REG_IN_LIM  = 3'd6,
        REG_OUT_LIM = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        TERM_B0,
        TERM_B1,
        TERM_B2,
        TERM_A1,
        TERM_A2,
        TERM_AW
    } term_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_OUT,
        S_AWMUL,
        S_DIVINIT,
        S_DIV,
        S_DIVEND,
        S_DONE
    } state_t;

    typedef struct packed {
        logic  load_x;
        logic  mul_en;
        term_t term;
        logic  acc_clr;
        logic  acc_en;
        logic  out_upd;
        logic  div_init;
        logic  div_step;
        logic  div_done;
        logic  out_load;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic sum_b_zero;
        logic out_busy;
    } status_t;

endpackage

// ----- src/biquad_ctrl.sv -----
// Sequencer for the biquad IIR unit: MAC term order and anti-windup divide.
// Depends on biquad_pkg.
module biquad_ctrl #(
    parameter int DATA_WIDTH = biquad_pkg::DATA_WIDTH_DEF,
    parameter int COEF_WIDTH = biquad_pkg::COEF_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  biquad_pkg::status_t status,
    output biquad_pkg::cmd_t    cmd
);

    localparam int NW    = DATA_WIDTH + COEF_WIDTH + 4;
    localparam int CNT_W = $clog2(NW);

    biquad_pkg::state_t state_reg, state_next;
    biquad_pkg::term_t  term_reg, term_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= biquad_pkg::S_IDLE;
            term_reg  <= biquad_pkg::TERM_B0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.term   = term_reg;
        in_stall   = (state_reg != biquad_pkg::S_IDLE);
        unique case (state_reg)
            biquad_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_x = 1'b1;
                    cmd.acc_clr = 1'b1;
                    term_next = biquad_pkg::TERM_B0;
                    state_next = biquad_pkg::S_MUL;
                end
            end
            biquad_pkg::S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = biquad_pkg::S_ACC;
            end
            biquad_pkg::S_ACC:
            begin
                cmd.acc_en = 1'b1;
                if (term_reg == biquad_pkg::TERM_A2)
                begin
                    state_next = biquad_pkg::S_OUT;
                end
                else
                begin
                    term_next = biquad_pkg::term_t'(3'(term_reg) + 3'd1);
                    state_next = biquad_pkg::S_MUL;
                end
            end
            biquad_pkg::S_OUT:
            begin
                cmd.out_upd = 1'b1;
                if (status.hit && !status.sum_b_zero)
                begin
                    term_next = biquad_pkg::TERM_AW;
                    state_next = biquad_pkg::S_AWMUL;
                end
                else
                begin
                    state_next = biquad_pkg::S_DONE;
                end
            end
            biquad_pkg::S_AWMUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = biquad_pkg::S_DIVINIT;
            end
            biquad_pkg::S_DIVINIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next = '0;
                state_next = biquad_pkg::S_DIV;
            end
            biquad_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NW - 1))
                begin
                    state_next = biquad_pkg::S_DIVEND;
                end
            end
            biquad_pkg::S_DIVEND:
            begin
                cmd.div_done = 1'b1;
                state_next = biquad_pkg::S_DONE;
            end
            biquad_pkg::S_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next = biquad_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = biquad_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/biquad_dp.sv -----
// Datapath for the biquad IIR unit: config registers, shared multiplier,
// accumulator, histories, clamps, serial divider and output register.
// Depends on biquad_pkg.
module biquad_dp #(
    parameter int DATA_WIDTH = biquad_pkg::DATA_WIDTH_DEF,
    parameter int COEF_WIDTH = biquad_pkg::COEF_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [biquad_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [biquad_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [biquad_pkg::SAMPLE_W-1:0]     sample_in,
    input  logic                                out_stall,
    input  biquad_pkg::cmd_t                    cmd,
    output biquad_pkg::status_t                 status,
    output logic                                out_valid,
    output logic [biquad_pkg::SAMPLE_W-1:0]     filtered_out
);

    localparam int DW    = DATA_WIDTH;
    localparam int CW    = COEF_WIDTH;
    localparam int BW    = CW + 2;
    localparam int PW    = DW + BW;
    localparam int ACC_W = DW + CW + 5;
    localparam int NW    = PW + 2;
    localparam int RW    = CW + 3;
    localparam int FRAC  = CW - 2;
    localparam logic signed [63:0] DMAX64 = (64'sd1 <<< (DW - 1)) - 64'sd1;
    localparam logic signed [63:0] DMIN64 = -DMAX64 - 64'sd1;
    localparam logic signed [DW-1:0] DMAX = DMAX64[DW-1:0];
    localparam logic signed [DW-1:0] DMIN = DMIN64[DW-1:0];

    function automatic logic signed [DW-1:0] lim_sat(input logic [biquad_pkg::LIMIT_W-1:0] v);
        logic signed [63:0] e;
        e = 64'(signed'(v));
        if (e > DMAX64)
            e = DMAX64;
        else if (e < DMIN64)
            e = DMIN64;
        return e[DW-1:0];
    endfunction

    logic signed [CW-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic [3:0]           sat_reg;
    logic [63:0]          in_lim_reg, out_lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg      <= CW'(1) << FRAC;
            b1_reg      <= '0;
            b2_reg      <= '0;
            a1_reg      <= '0;
            a2_reg      <= '0;
            sat_reg     <= '0;
            in_lim_reg  <= '0;
            out_lim_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (biquad_pkg::cfg_reg_t'(cfg_index))
                biquad_pkg::REG_B0:      b0_reg      <= cfg_data[CW-1:0];
                biquad_pkg::REG_B1:      b1_reg      <= cfg_data[CW-1:0];
                biquad_pkg::REG_B2:      b2_reg      <= cfg_data[CW-1:0];
                biquad_pkg::REG_A1:      a1_reg      <= cfg_data[CW-1:0];
                biquad_pkg::REG_A2:      a2_reg      <= cfg_data[CW-1:0];
                biquad_pkg::REG_SAT:     sat_reg     <= cfg_data[3:0];
                biquad_pkg::REG_IN_LIM:  in_lim_reg  <= cfg_data;
                biquad_pkg::REG_OUT_LIM: out_lim_reg <= cfg_data;
                default:                 sat_reg     <= sat_reg;
            endcase
        end
    end

    logic signed [DW-1:0] in_lo, in_hi, out_lo, out_hi;
    assign in_lo  = lim_sat(in_lim_reg[31:0]);
    assign in_hi  = lim_sat(in_lim_reg[63:32]);
    assign out_lo = lim_sat(out_lim_reg[31:0]);
    assign out_hi = lim_sat(out_lim_reg[63:32]);

    // input clamp: low first, then high
    logic signed [63:0]   s64;
    logic signed [DW-1:0] x_raw, x_lo, x_cl;
    assign s64   = 64'(signed'(sample_in));
    assign x_raw = s64[DW-1:0];
    assign x_lo  = (sat_reg[0] && (x_raw < in_lo)) ? in_lo : x_raw;
    assign x_cl  = (sat_reg[1] && (x_lo > in_hi)) ? in_hi : x_lo;

    logic signed [BW-1:0] sum_a, sum_b;
    assign sum_b = BW'(b0_reg) + BW'(b1_reg) + BW'(b2_reg);
    assign sum_a = (BW'(1) <<< FRAC) + BW'(a1_reg) + BW'(a2_reg);

    logic signed [DW-1:0] x_reg, xh0_reg, xh1_reg, yh0_reg, yh1_reg, yc_reg;
    logic signed [DW-1:0] op_a;
    logic signed [BW-1:0] op_b;
    logic signed [PW-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    always_comb
    begin
        unique case (cmd.term)
            biquad_pkg::TERM_B0: begin op_a = x_reg;   op_b = BW'(b0_reg);  end
            biquad_pkg::TERM_B1: begin op_a = xh0_reg; op_b = BW'(b1_reg);  end
            biquad_pkg::TERM_B2: begin op_a = xh1_reg; op_b = BW'(b2_reg);  end
            biquad_pkg::TERM_A1: begin op_a = yh0_reg; op_b = -BW'(a1_reg); end
            biquad_pkg::TERM_A2: begin op_a = yh1_reg; op_b = -BW'(a2_reg); end
            biquad_pkg::TERM_AW: begin op_a = yc_reg;  op_b = sum_a;        end
            default:             begin op_a = '0;      op_b = '0;           end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= PW'(op_a) * PW'(op_b);
        if (cmd.load_x)
            x_reg <= x_cl;
        if (cmd.acc_clr)
            acc_reg <= ACC_W'(1) << (FRAC - 1);
        else if (cmd.acc_en)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    // round, shift to data grid, saturate
    logic signed [ACC_W-1:0] y_sh;
    logic [ACC_W-DW:0]       y_top;
    logic signed [DW-1:0]    y_s, y_lo, y_cl;
    logic                    hit_lo, hit_hi;
    assign y_sh  = acc_reg >>> FRAC;
    assign y_top = y_sh[ACC_W-1:DW-1];
    assign y_s   = ((&y_top) || !(|y_top)) ? y_sh[DW-1:0] :
                   (y_sh[ACC_W-1] ? DMIN : DMAX);
    assign hit_lo = sat_reg[2] && (y_s < out_lo);
    assign y_lo   = hit_lo ? out_lo : y_s;
    assign hit_hi = sat_reg[3] && (y_lo > out_hi);
    assign y_cl   = hit_hi ? out_hi : y_lo;

    // anti-windup divider: floor((2|n| + |d|) / 2|d|)
    logic          neg_reg;
    logic [NW-1:0] dq_reg;
    logic [RW-1:0] rem_reg, den2_reg;
    logic [PW-1:0] mag_num;
    logic [BW-1:0] mag_den;
    logic [RW:0]   r2;
    logic          ge;
    logic signed [DW-1:0] aw_val;

    assign mag_num = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
    assign mag_den = sum_b[BW-1] ? BW'(-sum_b) : BW'(sum_b);
    assign r2      = {rem_reg, dq_reg[NW-1]};
    assign ge      = (r2 >= {1'b0, den2_reg});

    always_comb
    begin
        if (neg_reg)
            aw_val = (dq_reg > NW'(DMAX64 + 64'sd1)) ? DMIN : DW'(-dq_reg);
        else
            aw_val = (dq_reg > NW'(DMAX64)) ? DMAX : DW'(dq_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            neg_reg  <= prod_reg[PW-1] ^ sum_b[BW-1];
            dq_reg   <= (NW'(mag_num) << 1) + NW'(mag_den);
            rem_reg  <= '0;
            den2_reg <= RW'(mag_den) << 1;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? RW'(r2 - {1'b0, den2_reg}) : RW'(r2);
            dq_reg  <= {dq_reg[NW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xh0_reg <= '0;
            xh1_reg <= '0;
            yh0_reg <= '0;
            yh1_reg <= '0;
        end
        else if (cmd.out_upd)
        begin
            xh1_reg <= xh0_reg;
            xh0_reg <= x_reg;
            if (hit_lo || hit_hi)
            begin
                yh0_reg <= y_cl;
                yh1_reg <= y_cl;
            end
            else
            begin
                yh1_reg <= yh0_reg;
                yh0_reg <= y_s;
            end
        end
        else if (cmd.div_done)
        begin
            xh0_reg <= aw_val;
            xh1_reg <= aw_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_upd)
            yc_reg <= y_cl;
    end

    logic signed [DW-1:0] out_reg;
    logic                 out_valid_reg;
    logic [63:0]          out_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_reg <= yc_reg;
    end

    assign out_z        = 64'(unsigned'(out_reg));
    assign filtered_out = out_z[biquad_pkg::SAMPLE_W-1:0];
    assign out_valid    = out_valid_reg;

    assign status.hit        = hit_lo || hit_hi;
    assign status.sum_b_zero = (sum_b == '0);
    assign status.out_busy   = out_valid_reg && out_stall;

endmodule

// ----- src/biquad_iir_with_saturation_unit.sv -----
// Top level of the biquad IIR unit with input/output clamping and anti-windup.
// Depends on biquad_pkg, biquad_ctrl, biquad_dp and the defines header.
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------
//  input   | in_valid / in_stall    | sample_in (32, Q16.16)
//  output  | out_valid / out_stall  | filtered_out (32, Q16.16)
//  config  | cfg_valid / cfg_ready  | cfg_index (3), cfg_data (64)
//
// Schedule: five multiply/accumulate pairs per sample on one shared
//   multiplier; a clamp hit with nonzero b0+b1+b2 adds a pass through the
//   bit-serial rounding divider.
// Reset: coefficients to b0 = 1.0, all others zero, histories cleared.
// Stalls: a held output stalls only the final load; one sample in flight.
module biquad_iir_with_saturation_unit #(
    parameter int DATA_WIDTH = biquad_pkg::DATA_WIDTH_DEF,
    parameter int COEF_WIDTH = biquad_pkg::COEF_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [biquad_pkg::SAMPLE_W-1:0]   sample_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [biquad_pkg::SAMPLE_W-1:0]   filtered_out,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [biquad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [biquad_pkg::CFG_DATA_W-1:0] cfg_data
);

`include "biquad_iir_with_saturation_unit_defines.svh"

    biquad_pkg::cmd_t    cmd;
    biquad_pkg::status_t status;

    // registers take a beat in any cycle; writes must only arrive while idle, which the block does not enforce
    assign cfg_ready = 1'b1;

    biquad_ctrl #(
        .DATA_WIDTH(DATA_WIDTH),
        .COEF_WIDTH(COEF_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    biquad_dp #(
        .DATA_WIDTH(DATA_WIDTH),
        .COEF_WIDTH(COEF_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_in    (sample_in),
        .out_stall    (out_stall),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .filtered_out (filtered_out)
    );

    // an accepted beat blocks the input until the result is loaded
    `BQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "input taken twice")
    // the divider never runs while the input is open
    `BQ_ASSERT_IMPLY(a_div_busy, clk, rst_n, cmd.div_step, in_stall, "divide while idle")
    // a loaded result shows up on the output
    `BQ_ASSERT_NEXT(a_out_load, clk, rst_n, cmd.out_load, out_valid, "result lost")

endmodule

// ----- tb/tb_biquad_iir_with_saturation_unit.sv -----
// Self-checking testbench for the biquad IIR unit with clamping and anti-windup.
// Depends on biquad_pkg and biquad_iir_with_saturation_unit; drives random bursts and stalls.
`timescale 1ns / 100ps
`default_nettype none

module tb_biquad_iir_with_saturation_unit;

    localparam int CF = 30;
    localparam longint DMAX = 64'sh7fffffff;
    localparam longint DMIN = -64'sh80000000;
    localparam longint CYCLE_LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [31:0] sample_in = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [31:0] filtered_out;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [biquad_pkg::CFG_IDX_W-1:0] cfg_index = biquad_pkg::REG_B0;
    logic [biquad_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Filter state mirrored for prediction.
    longint b0, b1, b2, a1, a2;
    logic [3:0] clamp_mode;
    logic [63:0] in_lim, out_lim;
    longint x_hist [2];
    longint y_hist [2];

    logic [31:0] expected_samples [$];
    int errors = 0;
    longint cycles = 0;
    bit hold_off = 1'b0;       // long receiver stall request
    int idle_pct = 30;         // sender gap probability, percent
    int stall_pct = 30;        // receiver stall probability, percent

    biquad_iir_with_saturation_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .sample_in(sample_in),
        .out_valid(out_valid), .out_stall(out_stall), .filtered_out(filtered_out),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // Abort on a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_biquad_iir_with_saturation_unit NOT OK");
            $finish;
        end
    end

    // Saturate a wide signed value to the data range.
    function automatic longint sat_wide(input logic signed [127:0] v);
        if (v > DMAX) return DMAX;
        if (v < DMIN) return DMIN;
        return longint'(v);
    endfunction

    // Divide, rounding halves away from zero.
    function automatic longint div_round(input logic signed [127:0] num, input longint den);
        logic [127:0] un, ud, q;
        bit neg;
        neg = (num < 0) != (den < 0);
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        q = (2 * un + ud) / (2 * ud);
        return sat_wide(neg ? -$signed(q) : $signed(q));
    endfunction

    // Advance the mirrored filter by one sample and return the expected output.
    function automatic logic [31:0] filter_step(input logic [31:0] s);
        longint x, y, lo, hi, olo, ohi, sum_b, sum_a;
        logic signed [127:0] acc;
        bit hit;
        x = longint'($signed(s));
        lo = longint'($signed(in_lim[31:0]));
        hi = longint'($signed(in_lim[63:32]));
        olo = longint'($signed(out_lim[31:0]));
        ohi = longint'($signed(out_lim[63:32]));
        hit = 1'b0;
        if (clamp_mode[0] && x < lo) x = lo;
        if (clamp_mode[1] && x > hi) x = hi;
        acc = 128'(b0) * 128'(x) + 128'(b1) * 128'(x_hist[0]) + 128'(b2) * 128'(x_hist[1])
            - 128'(a1) * 128'(y_hist[0]) - 128'(a2) * 128'(y_hist[1])
            + (128'sd1 <<< (CF - 1));
        y = sat_wide(acc >>> CF);
        x_hist[1] = x_hist[0];
        x_hist[0] = x;
        y_hist[1] = y_hist[0];
        y_hist[0] = y;
        if (clamp_mode[2] && y < olo) begin y = olo; hit = 1'b1; end
        if (clamp_mode[3] && y > ohi) begin y = ohi; hit = 1'b1; end
        if (hit)
        begin
            sum_b = b0 + b1 + b2;
            y_hist[0] = y;
            y_hist[1] = y;
            if (sum_b != 0)
            begin
                sum_a = (64'sd1 <<< CF) + a1 + a2;
                x_hist[0] = div_round(128'(y) * 128'(sum_a), sum_b);
                x_hist[1] = x_hist[0];
            end
        end
        return y[31:0];
    endfunction

    // Write one register while the block is idle; mirror it.
    task automatic write_reg(input biquad_pkg::cfg_reg_t idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            biquad_pkg::REG_B0:      b0 = longint'($signed(val[31:0]));
            biquad_pkg::REG_B1:      b1 = longint'($signed(val[31:0]));
            biquad_pkg::REG_B2:      b2 = longint'($signed(val[31:0]));
            biquad_pkg::REG_A1:      a1 = longint'($signed(val[31:0]));
            biquad_pkg::REG_A2:      a2 = longint'($signed(val[31:0]));
            biquad_pkg::REG_SAT:     clamp_mode = val[3:0];
            biquad_pkg::REG_IN_LIM:  in_lim = val;
            biquad_pkg::REG_OUT_LIM: out_lim = val;
            default: ;
        endcase
    endtask

    task automatic set_coefs(input logic [31:0] c0, c1, c2, c3, c4);
        write_reg(biquad_pkg::REG_B0, {32'd0, c0});
        write_reg(biquad_pkg::REG_B1, {32'd0, c1});
        write_reg(biquad_pkg::REG_B2, {32'd0, c2});
        write_reg(biquad_pkg::REG_A1, {32'd0, c3});
        write_reg(biquad_pkg::REG_A2, {32'd0, c4});
    endtask

    // Send one sample beat; random gaps shape the sender bursts.
    task automatic send_sample(input logic [31:0] s);
        in_valid <= 1'b1;
        sample_in <= s;
        do @(posedge clk); while (in_stall);
        expected_samples.push_back(filter_step(s));
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Drain outstanding results and pause before a write.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
            default: return $urandom;
        endcase
    endfunction

    // Receiver stall pattern, plus a long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Check each output beat against the oldest expected sample.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t: unexpected output, expected none actual %h", $time, filtered_out);
                errors++;
            end
            else
            begin
                if (filtered_out !== expected_samples[0])
                begin
                    $display("%0t: filtered_out mismatch expected %h actual %h",
                             $time, expected_samples[0], filtered_out);
                    errors++;
                end
                void'(expected_samples.pop_front());
            end
        end
    end

    // Reset defaults: pass-through at unity gain.
    task automatic test_reset_passthrough();
        send_sample(32'h0001_0000);
        send_sample(32'h7fffffff);
        send_sample(32'h80000000);
        send_sample(32'h0);
        send_sample(32'hffffffff);
        wait_idle();
    endtask

    // Extreme coefficients drive the output into saturation.
    task automatic test_extremes();
        set_coefs(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_sample(32'h7fffffff);
        send_sample(32'h80000000);
        send_sample(32'h7fffffff);
        send_sample(32'h00000001);
        wait_idle();
    endtask

    // Clamps, including minimum above maximum and the anti-windup path.
    task automatic test_clamps();
        set_coefs(32'h20000000, 32'h10000000, 32'h10000000, 32'hc0000000, 32'h10000000);
        write_reg(biquad_pkg::REG_IN_LIM, {32'h0002_0000, 32'hfffe_0000});
        write_reg(biquad_pkg::REG_OUT_LIM, {32'h0001_0000, 32'hffff_0000});
        write_reg(biquad_pkg::REG_SAT, 64'hf);
        send_sample(32'h0010_0000);
        send_sample(32'hfff0_0000);
        send_sample(32'h0000_8000);
        wait_idle();
        write_reg(biquad_pkg::REG_IN_LIM, {32'h8000_0000, 32'h7fff_ffff});
        write_reg(biquad_pkg::REG_OUT_LIM, {32'hffff_0000, 32'h0001_0000});
        send_sample(32'hfff0_0000);
        send_sample(32'h0010_0000);
        wait_idle();
        // Zero feedforward sum: input history left as shifted.
        set_coefs(32'h40000000, 32'hc0000000, 32'h0, 32'h0, 32'h0);
        send_sample(32'h0100_0000);
        send_sample(32'hff00_0000);
        wait_idle();
    endtask

    // Long receiver hold-off while the sender keeps offering.
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            repeat (6) send_sample(rand_sample());
        join
        wait_idle();
    endtask

    // Random phases over several settings, idling and stall mixes.
    task automatic test_random();
        for (int phase = 0; phase < 17; phase++)
        begin
            idle_pct = (phase % 3 == 0) ? 0 : $urandom_range(60);
            stall_pct = (phase % 4 == 0) ? 0 : $urandom_range(70);
            if (phase % 2)
                set_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
            else
                // Stable-ish low-pass style coefficients in a modest range.
                set_coefs($urandom_range(0, 32'h2000_0000), $urandom_range(0, 32'h2000_0000),
                          $urandom_range(0, 32'h2000_0000),
                          32'($signed($urandom_range(0, 32'h4000_0000)) - 32'sh6000_0000),
                          $urandom_range(0, 32'h2000_0000));
            write_reg(biquad_pkg::REG_SAT, 64'($urandom_range(15)));
            write_reg(biquad_pkg::REG_IN_LIM, {$urandom, $urandom});
            write_reg(biquad_pkg::REG_OUT_LIM, {32'($urandom_range(0, 32'h0004_0000)),
                      32'($signed(32'h0) - $signed($urandom_range(0, 32'h0004_0000)))});
            repeat (48) send_sample(rand_sample());
            wait_idle();
        end
    endtask

    initial
    begin
        b0 = 64'sd1 <<< CF;
        b1 = 0; b2 = 0; a1 = 0; a2 = 0;
        clamp_mode = '0;
        in_lim = '0;
        out_lim = '0;
        x_hist = '{0, 0};
        y_hist = '{0, 0};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_reset_passthrough();
        test_extremes();
        test_clamps();
        test_backpressure();
        test_random();
        if (errors == 0)
            $display("tb_biquad_iir_with_saturation_unit OK");
        else
            $display("tb_biquad_iir_with_saturation_unit NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+src
src/biquad_pkg.sv
src/biquad_ctrl.sv
src/biquad_dp.sv
src/biquad_iir_with_saturation_unit.sv
tb/tb_biquad_iir_with_saturation_unit.sv
